### rtl/hmscd_pkg.sv
`timescale 1ns / 1ps

package hmscd_pkg;

	// Top value of the hours field; minutes and seconds wrap at SecMinTop.
	localparam logic [6:0] MaxHours  = 7'd99;
	localparam logic [5:0] SecMinTop = 6'd59;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_ADJUST = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		UNIT_SEC  = 2'd0,
		UNIT_MIN  = 2'd1,
		UNIT_HOUR = 2'd2,
		UNIT_NONE = 2'd3
	} unit_t;

	typedef struct packed {
		logic [6:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       running;
	} timer_state_t;

	// One adjust step on a value whose legal range is 0..top, with wraparound.
	function automatic logic [6:0] step_unit(input logic [6:0] v, input logic [6:0] top,
			input logic up);
		logic [6:0] r;
		if (up) begin
			r = (v >= top) ? 7'd0 : v + 7'd1;
		end else begin
			r = (v == 7'd0) ? top : v - 7'd1;
		end
		return r;
	endfunction

endpackage

### rtl/hmscd_next.sv
`timescale 1ns / 1ps

module hmscd_next (
	input  hmscd_pkg::timer_state_t cur,
	input  hmscd_pkg::opcode_t      opcode,
	input  hmscd_pkg::unit_t        unit,
	input  logic                    step_up,
	output hmscd_pkg::timer_state_t nxt,
	output logic                    expired
);
	import hmscd_pkg::*;

	logic [6:0] sec_step;
	logic [6:0] min_step;
	logic [6:0] hour_step;

	assign sec_step  = step_unit({1'b0, cur.seconds}, {1'b0, SecMinTop}, step_up);
	assign min_step  = step_unit({1'b0, cur.minutes}, {1'b0, SecMinTop}, step_up);
	assign hour_step = step_unit(cur.hours, MaxHours, step_up);

	always_comb begin
		nxt     = cur;
		expired = 1'b0;
		case (opcode)
			OP_TICK: begin
				if (cur.running) begin
					if (cur.seconds != 6'd0) begin
						nxt.seconds = cur.seconds - 6'd1;
					end else if (cur.minutes != 6'd0) begin
						nxt.minutes = cur.minutes - 6'd1;
						nxt.seconds = SecMinTop;
					end else if (cur.hours != 7'd0) begin
						nxt.hours   = cur.hours - 7'd1;
						nxt.minutes = SecMinTop;
						nxt.seconds = SecMinTop;
					end else begin
						// The tick after reaching zero ends the countdown.
						nxt     = '0;
						expired = 1'b1;
					end
				end
			end
			OP_TOGGLE: nxt.running = ~cur.running;
			OP_CLEAR:  nxt = '0;
			OP_ADJUST: begin
				if (!cur.running) begin
					case (unit)
						UNIT_SEC:  nxt.seconds = sec_step[5:0];
						UNIT_MIN:  nxt.minutes = min_step[5:0];
						UNIT_HOUR: nxt.hours   = hour_step;
						default:   nxt = cur;
					endcase
				end
			end
			default: nxt = cur;
		endcase
	end

endmodule

### rtl/hms_countdown_timer_unit.sv
`timescale 1ns / 1ps

// Hours/minutes/seconds countdown timer. Each input item is one event: a
// second tick, a run toggle, a clear, or an adjust of one unit (only while
// stopped). Every item produces exactly one output item with the count and
// run flag after the event, plus an expired flag that is set only on the tick
// that finds a running timer already at zero. An item is held in the input
// register and is then written, together with the updated count, into the
// output register; the count registers are the only feedback, so a new item
// is accepted every cycle when the output side is ready. A stalled output
// holds its item while one more item waits in the input register.
module hms_countdown_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // unit[1:0], step_up[2], zero fill [7:3]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // hours_left[6:0], minutes_left[12:7],
	                                   // seconds_left[18:13], is_running[19],
	                                   // expired[20], zero fill [23:21]
);
	import hmscd_pkg::*;

	logic         valid_s1;
	opcode_t      opcode_s1;
	unit_t        unit_s1;
	logic         step_up_s1;
	timer_state_t state_q;
	timer_state_t state_next;
	logic         expired_next;
	logic         out_valid_q;
	timer_state_t out_state_q;
	logic         out_expired_q;
	logic         out_free;
	logic         advance;

	assign out_free      = ~out_valid_q | m_axis_tready;
	assign advance       = valid_s1 & out_free;
	assign s_axis_tready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1  <= opcode_t'(s_axis_tuser);
			unit_s1    <= unit_t'(s_axis_tdata[1:0]);
			step_up_s1 <= s_axis_tdata[2];
		end
	end

	hmscd_next u_next (
		.cur     (state_q),
		.opcode  (opcode_s1),
		.unit    (unit_s1),
		.step_up (step_up_s1),
		.nxt     (state_next),
		.expired (expired_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q   <= state_next;
			out_expired_q <= expired_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_expired_q, out_state_q.running,
		out_state_q.seconds, out_state_q.minutes, out_state_q.hours};

	// The count never leaves its legal range.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seconds <= SecMinTop && state_q.minutes <= SecMinTop
		&& state_q.hours <= MaxHours)
		else $error("count out of range");

	// An expiring result shows a cleared, stopped timer.
	a_expired_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_expired_q |-> out_state_q == '0)
		else $error("expired result with nonzero state");

	// Expiry only comes from a running timer at zero.
	a_expired_origin: assert property (@(posedge clk) disable iff (!arst_n)
		advance && expired_next |-> state_q.running && state_q.hours == 7'd0
		&& state_q.minutes == 6'd0 && state_q.seconds == 6'd0)
		else $error("expiry without a running zero count");

	// With the output register empty the input side is never held off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output");

	// The count changes only when an item moves into the output register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("count changed without an item");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hmscd_pkg::*;

	typedef struct {
		opcode_t op;
		unit_t   which;
		bit      up;
		bit      drain_mark;  // Not an event: the sender waits here until all results are in.
	} timer_cmd_t;

	typedef struct {
		logic [6:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       running;
		logic       expired;
	} timer_reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // unit[1:0], step_up[2], zero fill [7:3]
	logic [1:0]  s_axis_tuser = 2'd0;   // opcode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // hours_left[6:0], minutes_left[12:7],
	                                    // seconds_left[18:13], is_running[19], expired[20]

	timer_cmd_t     pending_cmds[$];
	timer_reading_t expected_readings[$];
	timer_cmd_t     cur_cmd;
	int             queued_events;
	int             accepted_items = 0;
	int             results_seen = 0;
	int             expiries_seen = 0;
	int             cycle_no = 0;
	int             errors = 0;
	logic           hold_sink = 1'b0;
	bit             offering;
	bit             sink_stall;

	// Predicted timer state.
	logic [6:0] tm_hours;
	logic [5:0] tm_minutes;
	logic [5:0] tm_seconds;
	bit         tm_run;

	hms_countdown_timer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	initial begin
		#2_000_000;
		$display("FAIL hms_countdown_timer_unit");
		$finish;
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	// No random idling on either side during this window.
	function automatic bit quiet_window();
		return cycle_no >= 1500 && cycle_no < 2300;
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < 50) begin
			$display("mismatch at %0t: %s", $time, what);
		end
		errors++;
	endtask

	function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] top,
			input bit up);
		if (up) begin
			return (v >= top) ? 7'd0 : v + 7'd1;
		end
		return (v == 7'd0) ? top : v - 7'd1;
	endfunction

	task automatic zero_timer();
		tm_hours = '0;
		tm_minutes = '0;
		tm_seconds = '0;
		tm_run = 1'b0;
	endtask

	task automatic advance_timer(input timer_cmd_t cmd, output timer_reading_t rd);
		logic [6:0] wide;
		rd.expired = 1'b0;
		case (cmd.op)
			OP_TICK: begin
				if (tm_run) begin
					if (tm_seconds > 0) begin
						tm_seconds = tm_seconds - 6'd1;
					end else if (tm_minutes > 0) begin
						tm_minutes = tm_minutes - 6'd1;
						tm_seconds = SecMinTop;
					end else if (tm_hours > 0) begin
						tm_hours = tm_hours - 7'd1;
						tm_minutes = SecMinTop;
						tm_seconds = SecMinTop;
					end else begin
						zero_timer();
						rd.expired = 1'b1;
					end
				end
			end
			OP_TOGGLE: tm_run = !tm_run;
			OP_CLEAR: zero_timer();
			OP_ADJUST: begin
				if (!tm_run) begin
					case (cmd.which)
						UNIT_SEC: begin
							wide = wrap_step({1'b0, tm_seconds}, {1'b0, SecMinTop}, cmd.up);
							tm_seconds = wide[5:0];
						end
						UNIT_MIN: begin
							wide = wrap_step({1'b0, tm_minutes}, {1'b0, SecMinTop}, cmd.up);
							tm_minutes = wide[5:0];
						end
						UNIT_HOUR: tm_hours = wrap_step(tm_hours, MaxHours, cmd.up);
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		rd.hours = tm_hours;
		rd.minutes = tm_minutes;
		rd.seconds = tm_seconds;
		rd.running = tm_run;
	endtask

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		timer_reading_t rd;
		bit taken;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
			s_axis_tuser <= 2'd0;
			zero_timer();
		end else begin
			offering = s_axis_tvalid;
			taken = s_axis_tvalid && s_axis_tready;
			if (taken) begin
				advance_timer(cur_cmd, rd);
				expected_readings.push_back(rd);
				accepted_items <= accepted_items + 1;
				offering = 1'b0;
			end
			if (!offering && pending_cmds.size() > 0 && pending_cmds[0].drain_mark
					&& accepted_items + int'(taken) == results_seen) begin
				void'(pending_cmds.pop_front());
			end
			if (!offering && pending_cmds.size() > 0 && !pending_cmds[0].drain_mark
					&& (quiet_window() || $urandom_range(0, 99) >= 15)) begin
				cur_cmd = pending_cmds.pop_front();
				offering = 1'b1;
			end
			s_axis_tvalid <= offering;
			s_axis_tdata <= {5'd0, cur_cmd.up, cur_cmd.which};
			s_axis_tuser <= cur_cmd.op;
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		timer_reading_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (m_axis_tdata[20]) begin
					expiries_seen++;
				end
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result 0x%06h with nothing expected", m_axis_tdata));
				end else begin
					want = expected_readings.pop_front();
					if (m_axis_tdata[6:0] !== want.hours) begin
						report_mismatch($sformatf("hours_left %0d, expected %0d",
							m_axis_tdata[6:0], want.hours));
					end
					if (m_axis_tdata[12:7] !== want.minutes) begin
						report_mismatch($sformatf("minutes_left %0d, expected %0d",
							m_axis_tdata[12:7], want.minutes));
					end
					if (m_axis_tdata[18:13] !== want.seconds) begin
						report_mismatch($sformatf("seconds_left %0d, expected %0d",
							m_axis_tdata[18:13], want.seconds));
					end
					if (m_axis_tdata[19] !== want.running) begin
						report_mismatch($sformatf("is_running %b, expected %b",
							m_axis_tdata[19], want.running));
					end
					if (m_axis_tdata[20] !== want.expired) begin
						report_mismatch($sformatf("expired %b, expected %b",
							m_axis_tdata[20], want.expired));
					end
				end
			end
			sink_stall = hold_sink || (!quiet_window() && $urandom_range(0, 99) < 15);
			m_axis_tready <= !sink_stall;
		end
	end

	// Long receiver hold-off so that the block fills up and stalls its input.
	initial begin
		wait (accepted_items >= 400);
		@(posedge clk);
		hold_sink <= 1'b1;
		repeat (200) @(posedge clk);
		hold_sink <= 1'b0;
	end

	task automatic queue_cmd(input opcode_t op, input unit_t which, input bit up);
		timer_cmd_t c;
		c.op = op;
		c.which = which;
		c.up = up;
		c.drain_mark = 1'b0;
		pending_cmds.push_back(c);
		queued_events++;
	endtask

	task automatic queue_drain();
		timer_cmd_t c;
		c.op = OP_TICK;
		c.which = UNIT_SEC;
		c.up = 1'b0;
		c.drain_mark = 1'b1;
		pending_cmds.push_back(c);
	endtask

	function automatic unit_t any_unit();
		return unit_t'($urandom_range(0, 3));
	endfunction

	function automatic bit any_bit();
		return bit'($urandom_range(0, 1));
	endfunction

	initial begin
		int secs;
		int mins;
		int nticks;
		int stop_at;
		queued_events = 0;

		// Directed part: wraparound at both ends of every unit, ignored adjusts,
		// borrows from minutes and hours, and a start from zero that expires.
		queue_cmd(OP_TICK, UNIT_SEC, 1'b0);
		queue_cmd(OP_ADJUST, UNIT_HOUR, 1'b0);
		queue_cmd(OP_ADJUST, UNIT_HOUR, 1'b1);
		queue_cmd(OP_ADJUST, UNIT_MIN, 1'b0);
		queue_cmd(OP_ADJUST, UNIT_SEC, 1'b0);
		queue_cmd(OP_ADJUST, UNIT_MIN, 1'b1);
		queue_cmd(OP_ADJUST, UNIT_SEC, 1'b1);
		queue_cmd(OP_ADJUST, UNIT_NONE, 1'b1);
		queue_cmd(OP_ADJUST, UNIT_HOUR, 1'b1);
		queue_cmd(OP_TOGGLE, UNIT_NONE, 1'b0);
		queue_cmd(OP_ADJUST, UNIT_SEC, 1'b1);
		queue_cmd(OP_TICK, UNIT_HOUR, 1'b1);
		queue_cmd(OP_TICK, UNIT_NONE, 1'b0);
		queue_cmd(OP_TOGGLE, UNIT_SEC, 1'b1);
		queue_cmd(OP_CLEAR, UNIT_NONE, 1'b1);
		queue_cmd(OP_ADJUST, UNIT_MIN, 1'b1);
		queue_cmd(OP_TOGGLE, UNIT_MIN, 1'b0);
		queue_cmd(OP_TICK, UNIT_SEC, 1'b0);
		queue_cmd(OP_CLEAR, UNIT_SEC, 1'b0);
		queue_cmd(OP_TOGGLE, UNIT_HOUR, 1'b1);
		queue_cmd(OP_TICK, UNIT_SEC, 1'b1);
		queue_cmd(OP_TICK, UNIT_MIN, 1'b0);
		queue_cmd(OP_TOGGLE, UNIT_SEC, 1'b0);
		queue_cmd(OP_TOGGLE, UNIT_SEC, 1'b0);
		queue_cmd(OP_ADJUST, UNIT_SEC, 1'b0);
		queue_drain();

		while (queued_events < 1825) begin
			if ($urandom_range(0, 99) < 65) begin
				// A short countdown set up by adjusts, mostly run out to expiry.
				queue_cmd(OP_CLEAR, any_unit(), any_bit());
				secs = $urandom_range(0, 4);
				repeat (secs) queue_cmd(OP_ADJUST, UNIT_SEC, 1'b1);
				mins = 0;
				if ($urandom_range(0, 3) == 0) begin
					queue_cmd(OP_ADJUST, UNIT_MIN, 1'b1);
					mins = 1;
				end
				if ($urandom_range(0, 4) == 0) begin
					queue_cmd(OP_ADJUST, UNIT_SEC, 1'b0);
					secs = (secs == 0) ? 59 : secs - 1;
				end
				queue_cmd(OP_TOGGLE, any_unit(), any_bit());
				nticks = mins * 60 + secs + 1 + $urandom_range(0, 2);
				stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nticks) : -1;
				for (int k = 0; k < nticks; k++) begin
					if (k == stop_at) begin
						queue_cmd(OP_TOGGLE, any_unit(), any_bit());
						queue_cmd(OP_ADJUST, any_unit(), any_bit());
						queue_cmd(OP_TOGGLE, any_unit(), any_bit());
					end
					if ($urandom_range(0, 9) == 0) begin
						queue_cmd(OP_ADJUST, any_unit(), any_bit());
					end
					queue_cmd(OP_TICK, any_unit(), any_bit());
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					queue_cmd(opcode_t'($urandom_range(0, 3)), any_unit(), any_bit());
				end
			end
			if ($urandom_range(0, 59) == 0) begin
				queue_drain();
			end
		end

		@(negedge clk);
		while (pending_cmds.size() != 0 || s_axis_tvalid || accepted_items != results_seen) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
		if (expected_readings.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_readings.size()));
		end
		$display("Ran %0d timer events through the block and checked %0d results,",
			accepted_items, results_seen);
		$display("%0d of them expiries, with stalls on both sides and one long output hold-off.",
			expiries_seen);
		if (errors == 0) begin
			$display("PASS hms_countdown_timer_unit");
		end else begin
			$display("FAIL hms_countdown_timer_unit");
		end
		$finish;
	end

endmodule

### files.f
rtl/hmscd_pkg.sv
rtl/hmscd_next.sv
rtl/hms_countdown_timer_unit.sv
bench/testbench.sv
